/* design/wcf_pkg.sv */
// Shared types, constants and star-closure logic for the wildcard title filter.
// No dependencies; used by wcf_matcher and wildcard_title_filter.
package wcf_pkg;

  // Pattern slots and character width
  localparam int PATTERN_CHARS = 16;
  localparam int CHAR_BITS     = 16;
  localparam int REG_CHARS     = 16;
  localparam int FIELD_W       = 16;
  localparam int CFG_W         = 64;
  localparam int LEN_FIELD_W   = 5;
  localparam int CFG_IDX_W     = 3;
  localparam int CNT_W         = 16;

  localparam int PAT_MAX  = (PATTERN_CHARS < REG_CHARS) ? PATTERN_CHARS : REG_CHARS;
  localparam int LIVE_W   = PAT_MAX + 1;
  localparam int LEN_W    = $clog2(LIVE_W);
  localparam int CMP_BITS = (CHAR_BITS < FIELD_W) ? CHAR_BITS : FIELD_W;
  localparam int CHARS_PER_REG = CFG_W / FIELD_W;

  localparam logic [FIELD_W-1:0] CHAR_MASK     = FIELD_W'((33'd1 << CMP_BITS) - 33'd1);
  localparam logic [FIELD_W-1:0] STAR_CHAR     = FIELD_W'(42);
  localparam logic [FIELD_W-1:0] QUESTION_CHAR = FIELD_W'(63);

  typedef logic [FIELD_W-1:0]              char_t;
  typedef logic [PAT_MAX-1:0][FIELD_W-1:0] pat_t;
  typedef logic [LIVE_W-1:0]               live_t;
  typedef logic [LEN_W-1:0]                len_t;
  typedef logic [PAT_MAX-1:0]              slot_t;
  typedef logic [CNT_W-1:0]                cnt_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHARS_FIRST    = 3'd0,
    REG_CHARS_SECOND   = 3'd1,
    REG_CHARS_THIRD    = 3'd2,
    REG_CHARS_FOURTH   = 3'd3,
    REG_PATTERN_LENGTH = 3'd4
  } cfg_reg_t;

  // Flag the active slots that hold a star
  function automatic slot_t star_slots(input pat_t pat, input len_t n);
    slot_t s;
    for (int i = 0; i < PAT_MAX; i++) begin
      s[i] = (len_t'(i) < n) && ((pat[i] & CHAR_MASK) == STAR_CHAR);
    end
    return s;
  endfunction

  // Propagate live positions across runs of stars
  function automatic live_t star_closure(input live_t v, input pat_t pat, input len_t n);
    slot_t star;
    live_t r;
    logic  run;
    star = star_slots(pat, n);
    for (int k = 0; k < LIVE_W; k++) begin
      r[k] = v[k];
      run  = 1'b1;
      for (int i = k - 1; i >= 0; i--) begin
        run  = run & star[i];
        r[k] = r[k] | (v[i] & run);
      end
    end
    return r;
  endfunction

endpackage

/* design/wcf_matcher.sv */
// One-character step of the glob matcher over the live position vector.
// Depends on wcf_pkg for types and the star closure.
module wcf_matcher (
  input  wcf_pkg::live_t live,
  input  wcf_pkg::pat_t  pat,
  input  wcf_pkg::len_t  len,
  input  wcf_pkg::char_t text_char,
  input  logic           empty_title,
  output wcf_pkg::live_t stepped,
  output logic           hit
);
  import wcf_pkg::*;

  live_t closed;
  live_t moved;
  slot_t star;
  char_t c;

  // Close the held vector over stars, then consume the character unless the title is empty
  always_comb begin
    closed = star_closure(live, pat, len);
    star   = star_slots(pat, len);
    c      = text_char & CHAR_MASK;
    moved  = '0;
    for (int j = 0; j < PAT_MAX; j++) begin
      if (closed[j] && (len_t'(j) < len)) begin
        if (star[j]) begin
          moved[j] = 1'b1;
        end else if (((pat[j] & CHAR_MASK) == QUESTION_CHAR) ||
                     ((pat[j] & CHAR_MASK) == c)) begin
          moved[j+1] = 1'b1;
        end
      end
    end
    stepped = empty_title ? closed : star_closure(moved, pat, len);
    hit     = stepped[len];
  end

endmodule

/* design/wildcard_title_filter.sv */
// Wildcard title filter: streams title characters one request at a time and tests each
// title against a glob pattern ('*' any run, '?' one character) of up to 16 characters
// set through the configuration port. One request is taken every cycle, except that a
// title's last request stalls while the result register is full and stalled. A title's
// result is registered from the 17-bit live position vector held after the input register.
// Requests that do not end a title give no result. Title and match counters wrap at 16 bits.
module wildcard_title_filter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [wcf_pkg::FIELD_W-1:0]    text_char,
  input  logic                           title_end,
  input  logic                           empty_title,
  input  logic                           new_pass,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic                           matched,
  output logic [wcf_pkg::CNT_W-1:0]      title_index,
  output logic [wcf_pkg::CNT_W-1:0]      filtered_position,
  input  logic                           cfg_write,
  input  logic [wcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wcf_pkg::CFG_W-1:0]      cfg_data
);
  import wcf_pkg::*;

  logic [CHARS_PER_REG-1:0][CFG_W-1:0] pattern_regs;
  logic [LEN_FIELD_W-1:0]              pattern_length;
  pat_t  pat;
  len_t  len;

  logic  s1_valid;
  char_t s1_char;
  logic  s1_end;
  logic  s1_empty;
  logic  s1_pass;
  logic  s1_fire;
  logic  out_free;

  live_t live;
  live_t live_next;
  live_t stepped;
  live_t restart;
  logic  hit;
  cnt_t  title_counter;
  cnt_t  match_counter;
  cnt_t  title_base;
  cnt_t  match_base;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_regs   <= '0;
      pattern_length <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CHARS_FIRST:    pattern_regs[0] <= cfg_data;
        REG_CHARS_SECOND:   pattern_regs[1] <= cfg_data;
        REG_CHARS_THIRD:    pattern_regs[2] <= cfg_data;
        REG_CHARS_FOURTH:   pattern_regs[3] <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length  <= cfg_data[LEN_FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack pattern characters and saturate the length
  always_comb begin
    for (int i = 0; i < PAT_MAX; i++) begin
      pat[i] = pattern_regs[i / CHARS_PER_REG][FIELD_W*(i % CHARS_PER_REG) +: FIELD_W];
    end
    if (pattern_length > LEN_FIELD_W'(PAT_MAX)) begin
      len = len_t'(PAT_MAX);
    end else begin
      len = len_t'(pattern_length);
    end
  end

  // Handshake: a request without result always retires
  assign out_free   = !result_valid || !result_stall;
  assign s1_fire    = s1_valid && (!s1_end || out_free);
  assign item_stall = s1_valid && !s1_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_char  <= text_char;
      s1_end   <= title_end;
      s1_empty <= empty_title;
      s1_pass  <= new_pass;
    end
  end

  wcf_matcher u_matcher (
    .live        (live),
    .pat         (pat),
    .len         (len),
    .text_char   (s1_char),
    .empty_title (s1_empty),
    .stepped     (stepped),
    .hit         (hit)
  );

  // Restart the vector at the start position under the current pattern
  always_comb begin
    restart    = star_closure(live_t'(1), pat, len);
    live_next  = s1_end ? restart : stepped;
    title_base = s1_pass ? '0 : title_counter;
    match_base = s1_pass ? '0 : match_counter;
  end

  // Live vector and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      live          <= live_t'(1);
      title_counter <= '0;
      match_counter <= '0;
    end else if (s1_fire) begin
      live <= live_next;
      if (s1_end) begin
        title_counter <= title_base + cnt_t'(1);
        match_counter <= match_base + cnt_t'(hit);
      end else begin
        title_counter <= title_base;
        match_counter <= match_base;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire && s1_end) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_end) begin
      matched           <= hit;
      title_index       <= title_base;
      filtered_position <= match_base;
    end
  end

  // Checks
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !item_stall) else $error("stall raised with empty input register");

  a_restart_live: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_end) |=> live[0]) else $error("start position lost after title end");

  a_title_count: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_end) |=> (title_counter == cnt_t'($past(title_base) + cnt_t'(1))))
    else $error("title counter did not advance");

  a_result_fields: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_end) |=> (result_valid && title_index == $past(title_base)))
    else $error("result not loaded at title end");

endmodule

/* bench/tb_wildcard_title_filter.sv */
// Testbench for wildcard_title_filter: streams titles through the block and checks each
// title result against a cycle-free glob matcher kept alongside it.
// Depends on wcf_pkg (design/wcf_pkg.sv) and the wildcard_title_filter top level.
module tb_wildcard_title_filter;
  import wcf_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_CHARS   = 115;
  localparam int PAT_WORDS     = REG_CHARS / CHARS_PER_REG;

  typedef struct packed {
    char_t ch;
    logic  last;
    logic  no_char;
    logic  fresh_pass;
  } request_t;

  typedef struct packed {
    logic hit;
    cnt_t index;
    cnt_t slot;
  } verdict_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  char_t                text_char    = '0;
  logic                 title_end    = 1'b0;
  logic                 empty_title  = 1'b0;
  logic                 new_pass     = 1'b0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic                 matched;
  cnt_t                 title_index;
  cnt_t                 filtered_position;
  logic                 cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = REG_CHARS_FIRST;
  logic [CFG_W-1:0]     cfg_data     = '0;

  // Matcher state and its copy of the configuration
  logic [CFG_W-1:0]       pat_words [PAT_WORDS];
  logic [LEN_FIELD_W-1:0] pat_len_reg;
  live_t                  live_vec;
  cnt_t                   titles_seen;
  cnt_t                   matches_seen;

  request_t title_requests [$];
  verdict_t verdicts_due [$];
  verdict_t due;
  char_t    next_pat [PAT_MAX];
  cfg_reg_t char_regs [PAT_WORDS] =
    '{REG_CHARS_FIRST, REG_CHARS_SECOND, REG_CHARS_THIRD, REG_CHARS_FOURTH};

  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  int queued_count;
  int cycle_count;

  wildcard_title_filter dut (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_stall        (item_stall),
    .text_char         (text_char),
    .title_end         (title_end),
    .empty_title       (empty_title),
    .new_pass          (new_pass),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .matched           (matched),
    .title_index       (title_index),
    .filtered_position (filtered_position),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pattern length in use, saturated to the slots available
  function automatic int unsigned used_len();
    int unsigned n;
    n = 32'(pat_len_reg);
    if (n > PAT_MAX) n = PAT_MAX;
    return n;
  endfunction

  function automatic char_t pat_at(int unsigned i);
    return pat_words[i / CHARS_PER_REG][FIELD_W * (i % CHARS_PER_REG) +: FIELD_W] & CHAR_MASK;
  endfunction

  // Carry each live position over the star that follows it
  function automatic live_t close_stars(live_t v);
    for (int unsigned j = 0; j < used_len(); j++) begin
      if (v[j] && pat_at(j) == STAR_CHAR) v[j + 1] = 1'b1;
    end
    return v;
  endfunction

  // Consume one text character
  function automatic live_t step_live(live_t v, char_t c);
    live_t nv;
    char_t p;
    nv = '0;
    c  = c & CHAR_MASK;
    for (int unsigned j = 0; j < used_len(); j++) begin
      if (v[j]) begin
        p = pat_at(j);
        if (p == STAR_CHAR) nv[j] = 1'b1;
        else if (p == QUESTION_CHAR || p == c) nv[j + 1] = 1'b1;
      end
    end
    return close_stars(nv);
  endfunction

  // Advance the matcher by one accepted request and queue any title result
  function automatic void take_request(request_t r);
    logic hit;
    if (r.fresh_pass) begin
      titles_seen  = '0;
      matches_seen = '0;
    end
    live_vec = close_stars(live_vec);
    if (!r.no_char) live_vec = step_live(live_vec, r.ch);
    if (r.last) begin
      hit = live_vec[used_len()];
      verdicts_due.push_back('{hit: hit, index: titles_seen, slot: matches_seen});
      titles_seen++;
      if (hit) matches_seen++;
      live_vec = close_stars(LIVE_W'(1));
    end
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        take_request('{ch: text_char, last: title_end, no_char: empty_title,
                       fresh_pass: new_pass});
      end
      if (!item_valid || !item_stall) begin
        if (title_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          text_char   <= title_requests[0].ch;
          title_end   <= title_requests[0].last;
          empty_title <= title_requests[0].no_char;
          new_pass    <= title_requests[0].fresh_pass;
          item_valid  <= 1'b1;
          void'(title_requests.pop_front());
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each result with the oldest expected one
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected result: matched %0d title_index %0d filtered_position %0d",
                 matched, title_index, filtered_position);
          errors++;
        end else begin
          due = verdicts_due.pop_front();
          if (matched !== due.hit) begin
            $error("matched: expected %0d, got %0d", due.hit, matched);
            errors++;
          end
          if (title_index !== due.index) begin
            $error("title_index: expected %0d, got %0d", due.index, title_index);
            errors++;
          end
          if (filtered_position !== due.slot) begin
            $error("filtered_position: expected %0d, got %0d", due.slot, filtered_position);
            errors++;
          end
        end
      end
      result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_PATTERN_LENGTH) pat_len_reg = value[LEN_FIELD_W-1:0];
    else pat_words[2'(idx)] = value;
  endtask

  // Pack next_pat into the character registers, then set the length with junk above it
  task automatic load_pattern(logic [LEN_FIELD_W-1:0] len);
    logic [CFG_W-1:0] word;
    for (int w = 0; w < PAT_WORDS; w++) begin
      for (int k = 0; k < CHARS_PER_REG; k++) begin
        word[FIELD_W * k +: FIELD_W] = next_pat[w * CHARS_PER_REG + k];
      end
      write_reg(char_regs[w], word);
    end
    word = {$urandom, $urandom};
    word[LEN_FIELD_W-1:0] = len;
    write_reg(REG_PATTERN_LENGTH, word);
  endtask

  // Hold until every request is taken and every result is back, then let the pipe drain
  task automatic settle();
    do begin
      @(posedge clk);
    end while (title_requests.size() != 0 || item_valid || verdicts_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic char_t any_char();
    case ($urandom_range(0, 7))
      0: return 16'h0061;
      1: return 16'h0062;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return STAR_CHAR;
      default: return char_t'($urandom);
    endcase
  endfunction

  function automatic char_t any_pattern_char();
    case ($urandom_range(0, 7))
      0, 1: return STAR_CHAR;
      2: return QUESTION_CHAR;
      3: return 16'h0061;
      4: return 16'h0062;
      5: return 16'h0000;
      6: return 16'hFFFF;
      default: return char_t'($urandom);
    endcase
  endfunction

  function automatic logic pass_roll();
    return $urandom_range(0, 39) == 0;
  endfunction

  task automatic add(char_t ch, logic last, logic no_char, logic fresh_pass);
    title_requests.push_back('{ch: ch, last: last, no_char: no_char, fresh_pass: fresh_pass});
    if (!no_char) queued_count++;
  endtask

  // Queue one title, sometimes closed by a request with no character
  task automatic queue_chars(char_t chars[$]);
    logic blank_end;
    blank_end = (chars.size() == 0) || ($urandom_range(0, 5) == 0);
    foreach (chars[i]) begin
      // drop in an ignored request now and then
      if ($urandom_range(0, 19) == 0) add(char_t'($urandom), 1'b0, 1'b1, pass_roll());
      add(chars[i], !blank_end && i == chars.size() - 1, 1'b0, pass_roll());
    end
    if (blank_end) add(char_t'($urandom), 1'b1, 1'b1, pass_roll());
  endtask

  // Build a title from the current pattern, spoiled once when no match is wanted
  task automatic queue_title(logic aim_hit);
    char_t chars[$];
    char_t p;
    for (int unsigned i = 0; i < used_len(); i++) begin
      p = pat_at(i);
      if (p == STAR_CHAR) repeat ($urandom_range(0, 3)) chars.push_back(any_char());
      else if (p == QUESTION_CHAR) chars.push_back(any_char());
      else chars.push_back(p);
    end
    if (!aim_hit) begin
      case ($urandom_range(0, 2))
        0: if (chars.size() != 0) chars[$urandom_range(0, chars.size() - 1)] = any_char();
        1: chars.push_back(any_char());
        default: if (chars.size() != 0) chars.delete($urandom_range(0, chars.size() - 1));
      endcase
    end
    queue_chars(chars);
  endtask

  task automatic queue_noise();
    char_t chars[$];
    repeat ($urandom_range(0, 12)) chars.push_back(char_t'($urandom));
    queue_chars(chars);
  endtask

  task automatic choose_pattern(int kind);
    logic [LEN_FIELD_W-1:0] len;
    char_t fill;
    foreach (next_pat[i]) next_pat[i] = any_pattern_char();
    len = LEN_FIELD_W'($urandom_range(1, PAT_MAX));
    case (kind)
      1: len = LEN_FIELD_W'(PAT_MAX);
      // length beyond the slots saturates
      2: len = LEN_FIELD_W'($urandom_range(PAT_MAX + 1, (1 << LEN_FIELD_W) - 1));
      3: begin
        fill = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        foreach (next_pat[i]) next_pat[i] = fill;
        len = LEN_FIELD_W'(PAT_MAX);
      end
      4: begin
        foreach (next_pat[i]) next_pat[i] = char_t'($urandom);
        len = LEN_FIELD_W'($urandom_range(0, PAT_MAX));
      end
      5: begin
        case ($urandom_range(0, 2))
          0: foreach (next_pat[i]) next_pat[i] = STAR_CHAR;
          1: foreach (next_pat[i]) next_pat[i] = QUESTION_CHAR;
          default: ;
        endcase
        len = ($urandom_range(0, 2) == 2) ? '0 : LEN_FIELD_W'(PAT_MAX);
      end
      default: ;
    endcase
    load_pattern(len);
  endtask

  // Stimulus
  initial begin
    pat_words    = '{default: '0};
    pat_len_reg  = '0;
    titles_seen  = '0;
    matches_seen = '0;
    errors       = 0;
    queued_count = 0;
    live_vec     = close_stars(LIVE_W'(1));
    set_idling(29, 83);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty pattern after reset: only an empty title matches
    add(16'h0000, 1'b1, 1'b1, 1'b0);
    add(16'h0000, 1'b1, 1'b0, 1'b0);
    settle();

    // question, star, zero, all-ones, star
    next_pat = '{default: '0};
    next_pat[0] = QUESTION_CHAR;
    next_pat[1] = STAR_CHAR;
    next_pat[2] = 16'h0000;
    next_pat[3] = 16'hFFFF;
    next_pat[4] = STAR_CHAR;
    load_pattern(LEN_FIELD_W'(5));
    add(16'h1234, 1'b0, 1'b0, 1'b0);
    add(16'h0000, 1'b0, 1'b0, 1'b0);
    add(16'hFFFF, 1'b1, 1'b0, 1'b0);
    // new pass, ignored request mid-title, literal star and question mark in the text
    add(16'hFFFF, 1'b0, 1'b0, 1'b1);
    add(16'h0041, 1'b0, 1'b0, 1'b0);
    add(16'hFFFF, 1'b0, 1'b1, 1'b0);
    add(16'h0000, 1'b0, 1'b0, 1'b0);
    add(16'hFFFF, 1'b0, 1'b0, 1'b0);
    add(STAR_CHAR, 1'b0, 1'b0, 1'b0);
    add(QUESTION_CHAR, 1'b1, 1'b0, 1'b0);
    add(16'h0000, 1'b0, 1'b0, 1'b0);
    add(16'hFFFF, 1'b1, 1'b0, 1'b0);
    // close a title with a request carrying no character
    add(16'h0061, 1'b0, 1'b0, 1'b0);
    add(16'h0000, 1'b0, 1'b0, 1'b0);
    add(16'hFFFF, 1'b0, 1'b0, 1'b0);
    add(16'h5555, 1'b1, 1'b1, 1'b0);
    // leave a title open across a pattern change
    add(16'h0061, 1'b0, 1'b0, 1'b0);
    add(16'h0062, 1'b0, 1'b0, 1'b0);
    settle();
    next_pat = '{default: '0};
    next_pat[0] = 16'h0061;
    next_pat[1] = 16'h0062;
    next_pat[2] = 16'h0063;
    load_pattern(LEN_FIELD_W'(3));
    add(16'h0063, 1'b1, 1'b0, 1'b1);
    settle();

    // largest length field saturates to the full pattern
    next_pat = '{default: STAR_CHAR};
    next_pat[PAT_MAX - 1] = 16'h7FFF;
    load_pattern(LEN_FIELD_W'((1 << LEN_FIELD_W) - 1));
    add(16'h7FFF, 1'b1, 1'b0, 1'b0);
    settle();

    // random phases over varied patterns and idling
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase / 4)
        0: set_idling(29, 83);
        1: set_idling(83, 29);
        default: set_idling(0, 0);
      endcase
      choose_pattern(phase % 6);
      queued_count = 0;
      while (queued_count < PHASE_CHARS) begin
        if ($urandom_range(0, 9) == 0) queue_noise();
        else queue_title($urandom_range(0, 2) != 0);
      end
      settle();
    end

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule
